>>> hw/rtl/trl_pkg.sv
// Shared types, constants and result builders for the tape record loader.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package trl_pkg;

  localparam int MAX_PAYLOAD   = 1024;
  localparam int POS_W         = 11;
  localparam int SUM_W         = 8;
  localparam int BYTE_W        = 8;
  localparam int ADDR_W        = 16;
  localparam int NAME_W        = 48;
  localparam int REM_W         = 17;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = NAME_W;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
  localparam int HEADER_LEN      = 13;
  localparam int HEADER_SUM_LAST = 10;

  localparam logic [POS_W-1:0] POS_HDR_LEN   = POS_W'(HEADER_LEN);
  localparam logic [POS_W-1:0] POS_HDR_LAST  = POS_W'(HEADER_LEN - 1);
  localparam logic [POS_W-1:0] POS_SUM_LAST  = POS_W'(HEADER_SUM_LAST);
  localparam logic [POS_W-1:0] POS_PAY_FIRST = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PAY_LAST  = POS_W'(MAX_PAYLOAD + 2);
  localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [STATUS_W-1:0] ST_RECORD_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FILE_DONE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FORMAT_ERR   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM_ERR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ANY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_NAME = 1'd1;

  typedef struct packed {
    logic                   kind;
    logic [ADDR_W-1:0]      write_address;
    logic [BYTE_W-1:0]      write_data;
    logic [STATUS_W-1:0]    status;
    logic [NAME_W-1:0]      found_name;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } res_push_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_write_t;

  function automatic result_t make_write(input logic [ADDR_W-1:0] addr,
                                         input logic [BYTE_W-1:0] data,
                                         input logic              is_last);
    result_t r;
    r               = '0;
    r.kind          = KIND_WRITE;
    r.write_address = addr;
    r.write_data    = data;
    r.last          = is_last;
    return r;
  endfunction

  function automatic result_t make_status(input logic [STATUS_W-1:0] st,
                                          input logic [NAME_W-1:0]   nm,
                                          input logic                is_last);
    result_t r;
    r            = '0;
    r.kind       = KIND_STATUS;
    r.status     = st;
    r.found_name = nm;
    r.last       = is_last;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/trl_if.sv
// Valid/ready channel interfaces for tape bytes in and results out.
// Depends on trl_pkg for field widths.
`default_nettype none

interface trl_in_if ();
  import trl_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tape_byte;
  logic              end_of_record;
  modport source (output valid, tape_byte, end_of_record, input ready);
  modport sink   (input valid, tape_byte, end_of_record, output ready);
endinterface

interface trl_out_if ();
  import trl_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [ADDR_W-1:0]   write_address;
  logic [BYTE_W-1:0]   write_data;
  logic [STATUS_W-1:0] status;
  logic [NAME_W-1:0]   found_name;
  logic                last;
  modport source (output valid, kind, write_address, write_data, status, found_name, last,
                  input ready);
  modport sink   (input valid, kind, write_address, write_data, status, found_name, last,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/trl_deframer.sv
// Record deframer: header/data parsing, checksum, write generation, config registers.
// Depends on trl_pkg.
`default_nettype none

module trl_deframer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  trl_pkg::cfg_write_t       cfg,
  input  logic                      fire,
  input  logic [7:0]                in_byte,
  input  logic                      in_eor,
  output trl_pkg::res_push_t        push
);
  import trl_pkg::*;

  logic                match_any_r;
  logic [NAME_W-1:0]   wanted_name_r;

  logic                phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [BYTE_W-1:0]   prev_r, prev_nxt;
  logic [BYTE_W-1:0]   prev2_r, prev2_nxt;
  logic [NAME_W-1:0]   name_r, name_nxt;
  logic [ADDR_W-1:0]   start_r, start_nxt;
  logic [ADDR_W-1:0]   end_r, end_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic                sel_r, sel_nxt;
  logic                fault_r, fault_nxt;

  logic                fault;
  logic [STATUS_W-1:0] st;
  logic [NAME_W-1:0]   nm;
  logic                wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_any_r   <= 1'b1;
      wanted_name_r <= '0;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_MATCH_ANY:   match_any_r   <= cfg.wdata[0];
        CFG_WANTED_NAME: wanted_name_r <= cfg.wdata[NAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    prev_nxt  = prev_r;
    prev2_nxt = prev2_r;
    name_nxt  = name_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    rem_nxt   = rem_r;
    addr_nxt  = addr_r;
    sel_nxt   = sel_r;
    fault_nxt = fault_r;
    fault     = fault_r;
    st        = ST_RECORD_OK;
    nm        = '0;
    wr        = 1'b0;
    push      = '0;
    if (fire) begin
      if (pos_r == '0 && in_byte != SYNC_BYTE) fault = 1'b1;
      if (!phase_r) begin
        if (pos_r >= POS_HDR_LEN) fault = 1'b1;
        if (pos_r >= POS_W'(1) && pos_r <= POS_W'(6)) begin
          name_nxt = {name_r[NAME_W-9:0], in_byte};
        end else if (pos_r == POS_W'(7) || pos_r == POS_W'(8)) begin
          start_nxt = {start_r[7:0], in_byte};
        end else if (pos_r == POS_W'(9) || pos_r == POS_W'(10)) begin
          end_nxt = {end_r[7:0], in_byte};
        end
        if (pos_r >= POS_W'(1) && pos_r <= POS_SUM_LAST) sum_nxt = sum_r + in_byte;
        if (in_eor) begin
          if (fault || pos_r != POS_HDR_LAST || in_byte != '0) begin
            st = ST_FORMAT_ERR;
          end else if (prev_r != sum_nxt) begin
            st = ST_CHECKSUM_ERR;
          end else if (start_nxt > end_nxt) begin
            st = ST_FORMAT_ERR;
          end else begin
            phase_nxt = 1'b1;
            rem_nxt   = {1'b0, end_nxt} - {1'b0, start_nxt} + REM_W'(1);
            addr_nxt  = start_nxt;
            sel_nxt   = match_any_r || (name_nxt == wanted_name_r);
          end
          push.first_valid = 1'b1;
          push.first       = make_status(st, '0, 1'b1);
        end
      end else begin
        if (pos_r > POS_PAY_LAST) fault = 1'b1;
        if (pos_r >= POS_PAY_FIRST && pos_r <= POS_PAY_LAST) begin
          sum_nxt = sum_r + prev2_r;
          if (rem_r != '0) rem_nxt = rem_r - REM_W'(1);
          if (sel_r) begin
            wr               = 1'b1;
            push.first_valid = 1'b1;
            push.first       = make_write(addr_r, prev2_r, !in_eor);
            addr_nxt         = addr_r + ADDR_W'(1);
          end
        end
        if (in_eor) begin
          if (fault || pos_r < POS_W'(2) || in_byte != '0) begin
            st        = ST_FORMAT_ERR;
            phase_nxt = 1'b0;
          end else if (prev_r != sum_nxt) begin
            st        = ST_CHECKSUM_ERR;
            phase_nxt = 1'b0;
          end else if (rem_nxt == '0) begin
            phase_nxt = 1'b0;
            if (sel_r) begin
              st = ST_FILE_DONE;
              nm = name_r;
            end
          end
          if (wr) begin
            push.second_valid = 1'b1;
            push.second       = make_status(st, nm, 1'b1);
          end else begin
            push.first_valid = 1'b1;
            push.first       = make_status(st, nm, 1'b1);
          end
        end
      end
      if (in_eor) begin
        pos_nxt   = '0;
        sum_nxt   = '0;
        prev_nxt  = '0;
        prev2_nxt = '0;
        fault_nxt = 1'b0;
      end else begin
        prev2_nxt = prev_r;
        prev_nxt  = in_byte;
        fault_nxt = fault;
        if (pos_r != POS_MAX) pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      pos_r   <= '0;
      sum_r   <= '0;
      prev_r  <= '0;
      prev2_r <= '0;
      name_r  <= '0;
      start_r <= '0;
      end_r   <= '0;
      rem_r   <= '0;
      addr_r  <= '0;
      sel_r   <= 1'b0;
      fault_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      prev_r  <= prev_nxt;
      prev2_r <= prev2_nxt;
      name_r  <= name_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      rem_r   <= rem_nxt;
      addr_r  <= addr_nxt;
      sel_r   <= sel_nxt;
      fault_r <= fault_nxt;
    end
  end

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.second_valid |-> push.first_valid && push.first.kind == KIND_WRITE &&
                          !push.first.last && push.second.kind == KIND_STATUS)
    else $error("two results in one transfer must be write then status");

  a_write_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    push.first_valid && push.first.kind == KIND_WRITE |-> phase_r && sel_r)
    else $error("write issued outside a selected data record");

  a_eor_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_eor |=> pos_r == '0 && sum_r == '0 && !fault_r)
    else $error("record state not cleared after end of record");

endmodule

`default_nettype wire

>>> hw/rtl/trl_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on trl_pkg.
`default_nettype none

module trl_result_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  trl_pkg::res_push_t   push,
  output logic                 room,
  output logic                 head_valid,
  output trl_pkg::result_t     head,
  input  logic                 pop
);
  import trl_pkg::*;

  result_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_r, wr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_r, rd_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic [FIFO_CNT_W-1:0]   n_push;
  logic                    do_pop;

  assign head_valid = count_r != '0;
  assign head       = mem[rd_r];
  assign room       = count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign do_pop     = pop && head_valid;
  assign n_push     = FIFO_CNT_W'(push.first_valid) + FIFO_CNT_W'(push.second_valid);

  always_comb begin
    wr_nxt    = wr_r + n_push[FIFO_PTR_W-1:0];
    rd_nxt    = rd_r + FIFO_PTR_W'(do_pop);
    count_nxt = count_r + n_push - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.first_valid) mem[wr_r] <= push.first;
    if (push.second_valid) mem[wr_r + FIFO_PTR_W'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.first_valid |-> room)
    else $error("push into result queue without room");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r == rd_r + count_r[FIFO_PTR_W-1:0])
    else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire

>>> hw/rtl/tape_record_loader_core.sv
// A byte taken from in_ch is held in the input register; when it fires, its results are
// written into the result queue. Throughput: one byte per cycle while the queue has room;
// a byte that closes a data record with a write gives two results, and the output port moves
// one result per cycle while out_ch.ready is high, through a 4-entry queue. Reset:
// synchronous active-low rst_n clears record state and the queue, and sets match_any to 1 and
// wanted_name to 0. Depends on trl_pkg, trl_if, trl_deframer, trl_result_fifo.
`default_nettype none

module tape_record_loader_core (
  input  logic                               clk,
  input  logic                               rst_n,
  trl_in_if.sink                             in_ch,
  trl_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [trl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [trl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import trl_pkg::*;

  logic              s_valid_r;
  logic [BYTE_W-1:0] s_byte_r;
  logic              s_eor_r;
  logic              fire;
  logic              room;
  logic              head_valid;
  result_t           head;
  res_push_t         push;
  cfg_write_t        cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  assign fire        = s_valid_r && room;
  assign in_ch.ready = !s_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s_byte_r <= in_ch.tape_byte;
      s_eor_r  <= in_ch.end_of_record;
    end
  end

  trl_deframer u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (fire),
    .in_byte (s_byte_r),
    .in_eor  (s_eor_r),
    .push    (push)
  );

  trl_result_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_ch.ready)
  );

  assign out_ch.valid         = head_valid;
  assign out_ch.kind          = head.kind;
  assign out_ch.write_address = head.write_address;
  assign out_ch.write_data    = head.write_data;
  assign out_ch.status        = head.status;
  assign out_ch.found_name    = head.found_name;
  assign out_ch.last          = head.last;

endmodule

`default_nettype wire
